/* sv/dsp_pkg.sv */
package dsp_pkg;

    localparam int CNT_W = 6;
    localparam int IDX_W = 5;
    localparam int WIN_W = 16;
    localparam int DIST_W = 21;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;
    localparam int OUT_LIMIT = 32;
    localparam int MIN_COUNT = 2;
    localparam int COUNT_RESET = 32;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_RUN = 1'b1;

    typedef logic [DIST_W-1:0] dist_t;
    typedef logic [CNT_W-1:0] count_t;

    // Clamp a sum of a distance and a weight to the distance range.
    function automatic dist_t sat_dist(input logic [DIST_W+11:0] x);
        if (x > (DIST_W+12)'(DIST_MAX))
        begin
            return DIST_MAX;
        end
        return x[DIST_W-1:0];
    endfunction

endpackage

/* sv/dense_shortest_path.sv */
// Single-source shortest paths over a dense graph held as an adjacency matrix in an on-chip
// memory. A weight-write transaction is written into the matrix when it is accepted. A run
// transaction loads the distances from the source row, then does N-2 rounds, each a scan of
// the distance memory to pick the nearest unvisited vertex and a relaxation pass that reads
// one matrix entry and one distance per cycle, limited by the single read port of each
// memory, and finally emits N result transactions. The block takes no new input transaction
// until the last result of a run has been taken.
module dense_shortest_path #(
    parameter int MAX_VERTICES = 32,
    parameter int WEIGHT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // row[4:0], col[9:5], weight[25:10], source[30:26], zero[31]
    input  logic [31:0] s_tdata,
    // cmd[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // vertex[4:0], distance[25:5], zero[31:26]
    output logic [31:0] m_tdata,
    output logic        m_tlast
);

    localparam int DN = (MAX_VERTICES < dsp_pkg::OUT_LIMIT) ? MAX_VERTICES
                                                             : dsp_pkg::OUT_LIMIT;
    localparam int DW = $clog2(DN);
    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int AW = $clog2(DEPTH);
    localparam int SW = dsp_pkg::DIST_W + 12;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_INIT = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_RELAX = 3'd3;
    localparam logic [2:0] ST_OUT_RD = 3'd4;
    localparam logic [2:0] ST_OUT_LD = 3'd5;
    localparam logic [2:0] ST_OUT_HOLD = 3'd6;

    logic [WEIGHT_BITS-1:0] edge_mem [DEPTH];
    dsp_pkg::dist_t dist_mem [DN];

    logic [2:0] state_reg, state_next;
    logic [5:0] cfg_reg;
    logic [dsp_pkg::IDX_W-1:0] src_reg, src_next;
    dsp_pkg::count_t iss_reg, iss_next;
    dsp_pkg::count_t pidx_reg, pidx_next;
    logic pv_reg, pv_next;
    logic plast_reg, plast_next;
    dsp_pkg::count_t round_reg, round_next;
    logic [DW-1:0] pick_reg, pick_next;
    dsp_pkg::dist_t pickd_reg, pickd_next;
    logic found_reg, found_next;
    logic [DN-1:0] visited_reg, visited_next;
    logic ov_reg, ov_next;
    logic [dsp_pkg::IDX_W-1:0] ovtx_reg, ovtx_next;
    dsp_pkg::dist_t odist_reg, odist_next;
    logic olast_reg, olast_next;

    logic e_we;
    logic [AW-1:0] e_waddr, e_raddr;
    logic [WEIGHT_BITS-1:0] e_wdata, e_rdata;
    logic d_we;
    logic [DW-1:0] d_waddr, d_raddr;
    dsp_pkg::dist_t d_wdata, d_rdata;

    dsp_pkg::count_t n_cur;
    logic [dsp_pkg::IDX_W-1:0] in_row, in_col, in_source;
    logic [dsp_pkg::WIN_W-1:0] in_weight;
    logic [31:0] weight_ext;
    logic in_accept;
    logic issue;
    logic take;
    logic [DW-1:0] pick_c;
    dsp_pkg::dist_t pickd_c;
    logic found_c;
    dsp_pkg::dist_t init_d, cand_d;
    logic [DW-1:0] pslot;

    assign in_row = s_tdata[4:0];
    assign in_col = s_tdata[9:5];
    assign in_weight = s_tdata[25:10];
    assign in_source = s_tdata[30:26];
    assign weight_ext = {16'd0, in_weight};
    assign in_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    assign m_tvalid = ov_reg;
    assign m_tdata = {6'd0, odist_reg, ovtx_reg};
    assign m_tlast = olast_reg;

    always_comb
    begin
        if (cfg_reg < 6'(dsp_pkg::MIN_COUNT))
        begin
            n_cur = 6'(dsp_pkg::MIN_COUNT);
        end
        else if (cfg_reg > 6'(DN))
        begin
            n_cur = 6'(DN);
        end
        else
        begin
            n_cur = cfg_reg;
        end
    end

    assign pslot = pidx_reg[DW-1:0];
    assign init_d = dsp_pkg::sat_dist(SW'(e_rdata));
    assign cand_d = dsp_pkg::sat_dist(SW'(pickd_reg) + SW'(e_rdata));
    assign take = !visited_reg[pslot] && (!found_reg || d_rdata < pickd_reg);
    assign pick_c = take ? pslot : pick_reg;
    assign pickd_c = take ? d_rdata : pickd_reg;
    assign found_c = take || found_reg;
    assign issue = (state_reg == ST_INIT || state_reg == ST_SCAN || state_reg == ST_RELAX)
                   && (iss_reg < n_cur);

    assign e_waddr = AW'(32'(in_row) * MAX_VERTICES + 32'(in_col));
    assign e_wdata = weight_ext[WEIGHT_BITS-1:0];
    assign e_we = in_accept && (s_tuser == dsp_pkg::CMD_WRITE)
                  && (32'(in_row) < MAX_VERTICES) && (32'(in_col) < MAX_VERTICES);
    assign e_raddr = (state_reg == ST_RELAX)
                     ? AW'(32'(pick_reg) * MAX_VERTICES + 32'(iss_reg))
                     : AW'(32'(src_reg) * MAX_VERTICES + 32'(iss_reg));
    assign d_raddr = iss_reg[DW-1:0];
    assign d_waddr = pslot;

    always_comb
    begin
        d_we = 1'b0;
        d_wdata = init_d;
        if (pv_reg && state_reg == ST_INIT)
        begin
            d_we = 1'b1;
            d_wdata = (pidx_reg == 6'(src_reg)) ? '0 : init_d;
        end
        else if (pv_reg && state_reg == ST_RELAX)
        begin
            d_we = !visited_reg[pslot] && (cand_d < d_rdata);
            d_wdata = cand_d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            edge_mem[e_waddr] <= e_wdata;
        end
        e_rdata <= edge_mem[e_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (d_we)
        begin
            dist_mem[d_waddr] <= d_wdata;
        end
        d_rdata <= dist_mem[d_raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        src_next = src_reg;
        iss_next = iss_reg;
        pidx_next = iss_reg;
        pv_next = issue;
        plast_next = (iss_reg == n_cur - 6'd1);
        round_next = round_reg;
        pick_next = pick_reg;
        pickd_next = pickd_reg;
        found_next = found_reg;
        visited_next = visited_reg;
        ov_next = ov_reg;
        ovtx_next = ovtx_reg;
        odist_next = odist_reg;
        olast_next = olast_reg;
        if (issue)
        begin
            iss_next = iss_reg + 6'd1;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && s_tuser == dsp_pkg::CMD_RUN && 6'(in_source) < n_cur)
                begin
                    src_next = in_source;
                    visited_next = '0;
                    visited_next[in_source[DW-1:0]] = 1'b1;
                    iss_next = '0;
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                if (pv_reg && plast_reg)
                begin
                    iss_next = '0;
                    round_next = '0;
                    found_next = 1'b0;
                    state_next = (n_cur > 6'd2) ? ST_SCAN : ST_OUT_RD;
                end
            end
            ST_SCAN:
            begin
                if (pv_reg)
                begin
                    pick_next = pick_c;
                    pickd_next = pickd_c;
                    found_next = found_c;
                    if (plast_reg)
                    begin
                        iss_next = '0;
                        if (found_c)
                        begin
                            visited_next[pick_c] = 1'b1;
                            state_next = ST_RELAX;
                        end
                        else
                        begin
                            state_next = ST_OUT_RD;
                        end
                    end
                end
            end
            ST_RELAX:
            begin
                if (pv_reg && plast_reg)
                begin
                    iss_next = '0;
                    found_next = 1'b0;
                    round_next = round_reg + 6'd1;
                    state_next = (round_reg + 6'd3 < n_cur) ? ST_SCAN : ST_OUT_RD;
                end
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD:
            begin
                ov_next = 1'b1;
                ovtx_next = iss_reg[dsp_pkg::IDX_W-1:0];
                odist_next = d_rdata;
                olast_next = (iss_reg == n_cur - 6'd1);
                state_next = ST_OUT_HOLD;
            end
            ST_OUT_HOLD:
            begin
                if (m_tready)
                begin
                    ov_next = 1'b0;
                    if (olast_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        iss_next = iss_reg + 6'd1;
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cfg_reg <= 6'(dsp_pkg::COUNT_RESET);
            iss_reg <= '0;
            pv_reg <= 1'b0;
            plast_reg <= 1'b0;
            round_reg <= '0;
            found_reg <= 1'b0;
            visited_reg <= '0;
            ov_reg <= 1'b0;
            olast_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                cfg_reg <= cfg_data;
            end
            iss_reg <= iss_next;
            pv_reg <= pv_next;
            plast_reg <= plast_next;
            round_reg <= round_next;
            found_reg <= found_next;
            visited_reg <= visited_next;
            ov_reg <= ov_next;
            olast_reg <= olast_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg <= src_next;
        pidx_reg <= pidx_next;
        pick_reg <= pick_next;
        pickd_reg <= pickd_next;
        ovtx_reg <= ovtx_next;
        odist_reg <= odist_next;
    end

endmodule

/* sv/dsp_checker.sv */
module dsp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    logic [dsp_pkg::IDX_W-1:0] exp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg <= '0;
        end
        else if (m_tvalid && m_tready)
        begin
            exp_reg <= m_tlast ? '0 : exp_reg + 5'd1;
        end
    end

    // A stalled result transaction keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // Results of a run come out in vertex order starting at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[4:0] == exp_reg)
        else $error("result vertex out of order");

    // No input is taken while a result is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input accepted while result pending");

    // The last result ends the run and nothing follows at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("result after last");

    // An accepted input never produces a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !m_tvalid)
        else $error("result too early after input");

endmodule

bind dense_shortest_path dsp_checker u_dsp_checker (
    .clk(clk),
    .rst_n(rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
);

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

    import dsp_pkg::*;

    localparam int GRAPH_SIZE = 32;

    typedef struct {
        logic             cmd;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [WIN_W-1:0] weight;
        logic [IDX_W-1:0] source;
    } graph_cmd_t;

    typedef struct {
        logic [IDX_W-1:0] vertex;
        dist_t            distance;
        logic             last;
    } dist_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [5:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    graph_cmd_t   pending_cmds [$];
    dist_report_t expected_dists [$];
    graph_cmd_t   next_cmd;
    dist_report_t want_dist;

    logic [WIN_W-1:0] graph_weight [GRAPH_SIZE][GRAPH_SIZE];
    bit               weight_set [GRAPH_SIZE][GRAPH_SIZE];
    count_t           graph_count = count_t'(COUNT_RESET);

    bit in_fire = 1'b0;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;

    dense_shortest_path u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #4 clk = ~clk;

    function automatic int active_vertices();
        int n;
        n = int'(graph_count);
        if (n < MIN_COUNT)
        begin
            n = MIN_COUNT;
        end
        if (n > GRAPH_SIZE)
        begin
            n = GRAPH_SIZE;
        end
        return n;
    endfunction

    // Updates the weight matrix for a write, or, for a run whose source is below the vertex count,
    // solves the graph and queues the distance of every active vertex in index order.
    task automatic apply_transaction(input logic cmd, input logic [31:0] data);
        int n;
        int pick;
        int v;
        int r;
        logic [IDX_W-1:0] src;
        dist_t dist_val [GRAPH_SIZE];
        bit done [GRAPH_SIZE];
        logic [DIST_W:0] cand;
        dist_report_t rep;
        n = active_vertices();
        src = data[30:26];
        if (cmd == CMD_WRITE)
        begin
            graph_weight[data[4:0]][data[9:5]] = data[25:10];
        end
        else if (int'(src) < n)
        begin
            for (v = 0; v < n; v++)
            begin
                dist_val[v] = DIST_W'(graph_weight[src][v]);
                done[v] = 1'b0;
            end
            dist_val[src] = '0;
            done[src] = 1'b1;
            for (r = 0; r + 2 < n; r++)
            begin
                pick = -1;
                for (v = 0; v < n; v++)
                begin
                    if (!done[v] && (pick < 0 || dist_val[v] < dist_val[pick]))
                    begin
                        pick = v;
                    end
                end
                if (pick < 0)
                begin
                    break;
                end
                done[pick] = 1'b1;
                for (v = 0; v < n; v++)
                begin
                    if (!done[v])
                    begin
                        cand = {1'b0, dist_val[pick]} + (DIST_W + 1)'(graph_weight[pick][v]);
                        if (cand > (DIST_W + 1)'(DIST_MAX))
                        begin
                            cand = (DIST_W + 1)'(DIST_MAX);
                        end
                        if (cand[DIST_W-1:0] < dist_val[v])
                        begin
                            dist_val[v] = cand[DIST_W-1:0];
                        end
                    end
                end
            end
            for (v = 0; v < n; v++)
            begin
                rep.vertex = IDX_W'(v);
                rep.distance = dist_val[v];
                rep.last = (v + 1 == n);
                expected_dists.push_back(rep);
            end
        end
    endtask

    always @(posedge clk)
    begin
        in_fire = rst_n && s_tvalid && s_tready;
        if (in_fire)
        begin
            apply_transaction(s_tuser, s_tdata);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_dists.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got vertex %0d distance %0d",
                         $time, m_tdata[4:0], m_tdata[25:5]);
                mismatches++;
            end
            else
            begin
                want_dist = expected_dists.pop_front();
                if (m_tdata[4:0] !== want_dist.vertex)
                begin
                    $display("%0t: vertex expected %0d, got %0d",
                             $time, want_dist.vertex, m_tdata[4:0]);
                    mismatches++;
                end
                if (m_tdata[25:5] !== want_dist.distance)
                begin
                    $display("%0t: distance of vertex %0d expected %0d, got %0d",
                             $time, want_dist.vertex, want_dist.distance, m_tdata[25:5]);
                    mismatches++;
                end
                if (m_tlast !== want_dist.last)
                begin
                    $display("%0t: last flag of vertex %0d expected %0b, got %0b",
                             $time, want_dist.vertex, want_dist.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end
        else
        begin
            if (!s_tvalid || in_fire)
            begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    next_cmd = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {1'b0, next_cmd.source, next_cmd.weight, next_cmd.col,
                                next_cmd.row};
                    s_tuser <= next_cmd.cmd;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [WIN_W-1:0] random_weight();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2, 3, 4, 5: return WIN_W'($urandom_range(1, 20));
            default: return WIN_W'($urandom);
        endcase
    endfunction

    task automatic queue_write(input int r, input int c, input logic [WIN_W-1:0] w);
        graph_cmd_t item;
        item.cmd = CMD_WRITE;
        item.row = IDX_W'(r);
        item.col = IDX_W'(c);
        item.weight = w;
        item.source = IDX_W'($urandom);
        pending_cmds.push_back(item);
        weight_set[r][c] = 1'b1;
    endtask

    task automatic queue_run(input int s);
        graph_cmd_t item;
        item.cmd = CMD_RUN;
        item.row = IDX_W'($urandom);
        item.col = IDX_W'($urandom);
        item.weight = WIN_W'($urandom);
        item.source = IDX_W'(s);
        pending_cmds.push_back(item);
    endtask

    // Every weight that a run over the first n vertices can read is written beforehand.
    task automatic cover_graph(input int n);
        int r;
        int c;
        for (r = 0; r < n; r++)
        begin
            for (c = 0; c < n; c++)
            begin
                if (!weight_set[r][c])
                begin
                    queue_write(r, c, random_weight());
                end
            end
        end
    endtask

    task automatic wait_drained();
        do
        begin
            @(posedge clk);
        end
        while (pending_cmds.size() != 0 || s_tvalid || expected_dists.size() != 0);
        repeat (64) @(posedge clk);
    endtask

    task automatic reconfigure(input logic [5:0] value, input int gap, input int stall);
        wait_drained();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        graph_count = value;
        @(negedge clk);
        cfg_we <= 1'b0;
        send_gap_pct = gap;
        recv_stall_pct = stall;
    endtask

    task automatic random_phase(input logic [5:0] value, input int gap, input int stall,
                                input int items, input int run_pct);
        int n;
        int k;
        reconfigure(value, gap, stall);
        n = active_vertices();
        cover_graph(n);
        for (k = 0; k < items; k++)
        begin
            if ($urandom_range(99) < run_pct)
            begin
                if (n < GRAPH_SIZE && $urandom_range(9) == 0)
                begin
                    queue_run($urandom_range(n, GRAPH_SIZE - 1));
                end
                else
                begin
                    queue_run($urandom_range(n - 1));
                end
            end
            else if ($urandom_range(4) != 0)
            begin
                queue_write($urandom_range(n - 1), $urandom_range(n - 1), random_weight());
            end
            else
            begin
                queue_write($urandom_range(GRAPH_SIZE - 1), $urandom_range(GRAPH_SIZE - 1),
                            random_weight());
            end
        end
    endtask

    initial
    begin
        int r;
        int c;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // A count below two is clamped to two.
        reconfigure(6'd0, 0, 0);
        queue_write(0, 0, '1);
        queue_write(0, 1, '1);
        queue_write(1, 0, '0);
        queue_write(1, 1, '0);
        queue_write(GRAPH_SIZE - 1, GRAPH_SIZE - 1, '1);
        queue_write(GRAPH_SIZE - 1, 0, '0);
        queue_run(0);
        queue_run(1);
        queue_run(GRAPH_SIZE - 1);
        queue_run(2);

        reconfigure(6'd1, 0, 0);
        queue_write(1, 0, 16'd7);
        queue_run(1);
        queue_run(0);

        // Equal weights make the nearest-vertex choice a tie; the diagonal is never used.
        reconfigure(6'd3, 0, 0);
        for (r = 0; r < 3; r++)
        begin
            for (c = 0; c < 3; c++)
            begin
                queue_write(r, c, (r == c) ? 16'hFFFF : 16'd3);
            end
        end
        queue_run(0);
        queue_run(2);
        queue_run(3);

        random_phase(6'd5, 0, 0, 20, 35);
        random_phase(6'd8, 45, 0, 18, 35);
        random_phase(6'd7, 0, 45, 18, 40);
        random_phase(6'd4, 14, 14, 18, 40);
        random_phase(6'd2, 45, 0, 12, 45);
        random_phase(6'd6, 0, 0, 12, 40);

        wait_drained();
        if (mismatches == 0)
        begin
            $display("dense_shortest_path regression: pass");
        end
        else
        begin
            $display("dense_shortest_path regression: fail");
        end
        $finish;
    end

    initial
    begin
        #4000000;
        $display("dense_shortest_path regression: fail");
        $finish;
    end

endmodule
